@@ rtl/mlcr_pkg.sv @@
// Shared types, constants and helpers for the motor link command/reply unit.
`default_nettype none

package mlcr_pkg;

    // Frame and reply geometry
    localparam int FRAME_BYTES = 7;
    localparam int REPLY_LEN   = 5;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int CNT_W       = $clog2(REPLY_LEN + 1);
    localparam int ELAPSED_W   = 17;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Frame bytes
    localparam logic [7:0] SYNC_BYTE  = 8'hFF;
    localparam logic [7:0] START_BYTE = 8'h41;

    localparam logic [IDX_W-1:0]     FRAME_LAST  = IDX_W'(FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0]     REPLY_LAST  = CNT_W'(REPLY_LEN - 1);
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // Configuration port
    localparam int          PADDR_W         = 3;
    localparam int          PDATA_W         = 32;
    localparam logic        CFG_IDX_TIMEOUT = 1'b0;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd10;

    // Request codes
    localparam logic [1:0] REQ_CMD  = 2'd0;
    localparam logic [1:0] REQ_BYTE = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_REPLY   = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_BUSY    = 2'd3;

    // Link phase
    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_HUNT    = 3'b010,
        PH_COLLECT = 3'b100
    } t_phase;

    // Work passed from front to back
    typedef enum logic [1:0] {
        JOB_FRAME,
        JOB_REPLY,
        JOB_TIMEOUT,
        JOB_REFUSE
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [7:0]  motor_id;
        logic [7:0]  command;
        logic [15:0] argument;
        logic [7:0]  sum;
        logic [15:0] data;
    } t_job;

    // Pick one byte of a command frame
    function automatic logic [7:0] frame_byte(input t_job job, input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            IDX_W'(0): b = SYNC_BYTE;
            IDX_W'(1): b = START_BYTE;
            IDX_W'(2): b = job.motor_id;
            IDX_W'(3): b = job.command;
            IDX_W'(4): b = job.argument[7:0];
            IDX_W'(5): b = job.argument[15:8];
            IDX_W'(6): b = job.sum;
            default:   b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mlcr_if.sv @@
// Valid/ready channel interfaces for request and result items.
`default_nettype none

interface mlcr_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [7:0]         motor_id;
    logic [7:0]         command;
    logic signed [15:0] argument;
    logic [7:0]         rx_byte;

    modport source (output valid, req_type, motor_id, command, argument, rx_byte,
                    input ready);
    modport sink   (input valid, req_type, motor_id, command, argument, rx_byte,
                    output ready);
endinterface

interface mlcr_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         tx_byte;
    logic               last;
    logic signed [15:0] reply_data;

    modport source (output valid, kind, tx_byte, last, reply_data, input ready);
    modport sink   (input valid, kind, tx_byte, last, reply_data, output ready);
endinterface

`default_nettype wire

@@ rtl/mlcr_front.sv @@
// Front end: accepts request items, tracks the link phase and queues work.
`default_nettype none

module mlcr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    mlcr_req_if.sink           i_req,
    input  wire logic [15:0]   i_timeout_ms,
    input  wire logic          i_q_full,
    output mlcr_pkg::t_job     o_job,
    output logic               o_push
);

    mlcr_pkg::t_phase                    r_phase, n_phase;
    logic [mlcr_pkg::CNT_W-1:0]          r_count, n_count;
    logic [mlcr_pkg::ELAPSED_W-1:0]      r_elapsed, n_elapsed;
    logic [7:0]                          r_bytes [4];
    logic                                store_en;
    logic                                accept;
    logic                                busy;
    logic [7:0]                          reply_sum;
    logic [7:0]                          cmd_sum;

    assign i_req.ready = !i_q_full;
    assign accept      = i_req.valid && i_req.ready;
    assign busy        = (r_phase == mlcr_pkg::PH_HUNT) || (r_phase == mlcr_pkg::PH_COLLECT);
    assign reply_sum   = r_bytes[0] + r_bytes[1] + r_bytes[2] + r_bytes[3];
    assign cmd_sum     = i_req.motor_id + i_req.command + i_req.argument[7:0]
                       + i_req.argument[15:8];

    // Classify the item and work out the next link state
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_elapsed = r_elapsed;
        store_en  = 1'b0;
        o_push    = 1'b0;
        o_job     = '0;
        if (accept) begin
            case (i_req.req_type)
                mlcr_pkg::REQ_CMD: begin
                    o_push = 1'b1;
                    if (busy) begin
                        o_job.kind = mlcr_pkg::JOB_REFUSE;
                    end else begin
                        o_job.kind     = mlcr_pkg::JOB_FRAME;
                        o_job.motor_id = i_req.motor_id;
                        o_job.command  = i_req.command;
                        o_job.argument = i_req.argument;
                        o_job.sum      = cmd_sum;
                        n_phase        = mlcr_pkg::PH_HUNT;
                        n_count        = '0;
                        n_elapsed      = '0;
                    end
                end
                mlcr_pkg::REQ_BYTE: begin
                    if (r_phase == mlcr_pkg::PH_HUNT) begin
                        if (i_req.rx_byte == mlcr_pkg::START_BYTE) begin
                            n_count = '0;
                            n_phase = mlcr_pkg::PH_COLLECT;
                        end
                    end else if (r_phase == mlcr_pkg::PH_COLLECT) begin
                        if (r_count == mlcr_pkg::REPLY_LAST) begin
                            // Checksum byte: report on match, else hunt again
                            n_count = '0;
                            if (reply_sum == i_req.rx_byte) begin
                                n_phase    = mlcr_pkg::PH_IDLE;
                                o_push     = 1'b1;
                                o_job.kind = mlcr_pkg::JOB_REPLY;
                                o_job.data = {r_bytes[3], r_bytes[2]};
                            end else begin
                                n_phase = mlcr_pkg::PH_HUNT;
                            end
                        end else begin
                            store_en = 1'b1;
                            n_count  = r_count + 1'b1;
                        end
                    end
                end
                mlcr_pkg::REQ_TICK: begin
                    if (busy) begin
                        if (r_elapsed != mlcr_pkg::ELAPSED_MAX) begin
                            n_elapsed = r_elapsed + 1'b1;
                        end
                        if (n_elapsed > {1'b0, i_timeout_ms}) begin
                            n_phase    = mlcr_pkg::PH_IDLE;
                            n_count    = '0;
                            o_push     = 1'b1;
                            o_job.kind = mlcr_pkg::JOB_TIMEOUT;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Advance link state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= mlcr_pkg::PH_IDLE;
            r_count   <= '0;
            r_elapsed <= '0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_elapsed <= n_elapsed;
        end
    end

    // Store collected reply bytes
    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_bytes[r_count[1:0]] <= i_req.rx_byte;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mlcr_queue.sv @@
// Short work queue between the front end and the result sequencer.
`default_nettype none

module mlcr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mlcr_pkg::t_job i_job,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output mlcr_pkg::t_job      o_job
);

    mlcr_pkg::t_job                 r_mem [mlcr_pkg::QUEUE_DEPTH];
    logic [mlcr_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [mlcr_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [mlcr_pkg::QCNT_W-1:0]    r_count;
    logic                           do_pop;

    assign o_full  = (r_count == mlcr_pkg::QCNT_W'(mlcr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/mlcr_back.sv @@
// Back end: expands queued work into result items through an output register.
`default_nettype none

module mlcr_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire mlcr_pkg::t_job i_q_job,
    output logic                o_q_pop,
    mlcr_rsp_if.source          o_rsp
);

    mlcr_pkg::t_job                 r_job;
    logic                           r_active;
    logic [mlcr_pkg::IDX_W-1:0]     r_idx;
    logic                           r_out_valid;
    logic [1:0]                     r_out_kind;
    logic [7:0]                     r_out_tx;
    logic                           r_out_last;
    logic [15:0]                    r_out_data;
    logic                           out_free;
    logic                           emit;
    logic                           is_last;
    logic [1:0]                     res_kind;
    logic [7:0]                     res_tx;
    logic [15:0]                    res_data;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign emit     = r_active && out_free;
    assign is_last  = (r_job.kind != mlcr_pkg::JOB_FRAME) || (r_idx == mlcr_pkg::FRAME_LAST);
    assign o_q_pop  = i_q_valid && (!r_active || (emit && is_last));

    // Form the current result
    always_comb begin
        res_kind = mlcr_pkg::KIND_TX;
        res_tx   = 8'h00;
        res_data = 16'h0000;
        case (r_job.kind)
            mlcr_pkg::JOB_FRAME: begin
                res_kind = mlcr_pkg::KIND_TX;
                res_tx   = mlcr_pkg::frame_byte(r_job, r_idx);
            end
            mlcr_pkg::JOB_REPLY: begin
                res_kind = mlcr_pkg::KIND_REPLY;
                res_data = r_job.data;
            end
            mlcr_pkg::JOB_TIMEOUT: begin
                res_kind = mlcr_pkg::KIND_TIMEOUT;
            end
            mlcr_pkg::JOB_REFUSE: begin
                res_kind = mlcr_pkg::KIND_BUSY;
            end
            default: begin
            end
        endcase
    end

    // Sequence through the current job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
        end else if (o_q_pop) begin
            r_active <= 1'b1;
            r_idx    <= '0;
        end else if (emit && is_last) begin
            r_active <= 1'b0;
        end else if (emit) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Load the next job
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind <= res_kind;
            r_out_tx   <= res_tx;
            r_out_last <= is_last;
            r_out_data <= res_data;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.kind       = r_out_kind;
    assign o_rsp.tx_byte    = r_out_tx;
    assign o_rsp.last       = r_out_last;
    assign o_rsp.reply_data = r_out_data;

endmodule

`default_nettype wire

@@ rtl/motor_link_command_reply_unit.sv @@
// Top level of the motor link command/reply unit: config register and wiring.
//
//   channel   dir  handshake            payload
//   i_req     in   valid/ready          req_type, motor_id, command, argument, rx_byte
//   o_rsp     out  valid/ready          kind, tx_byte, last, reply_data
//   apb       in   psel/penable/pwrite  paddr, pwdata, prdata (timeout_ms at 0x0)
//
// An item is taken at any edge where the two-entry work queue has room, and the link state
// updates at that edge; with the sequencer free, the job then passes to the sequencer and
// its first result to the output register. A command taken in PH_IDLE yields seven result
// items, on consecutive cycles unless the output stalls; any other result is one item. A
// stalled output holds the output register and then fills the queue; input ready drops only
// while the queue is full. Reset is synchronous, active low; timeout_ms resets to 10.
`default_nettype none

module motor_link_command_reply_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    mlcr_req_if.sink                               i_req,
    mlcr_rsp_if.source                             o_rsp,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mlcr_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [mlcr_pkg::PDATA_W-1:0]      pwdata,
    output logic [mlcr_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready
);

    logic [15:0]        r_timeout_ms;
    logic               reg_sel;
    mlcr_pkg::t_job     push_job;
    logic               push;
    logic               q_full;
    logic               q_valid;
    mlcr_pkg::t_job     q_job;
    logic               q_pop;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[mlcr_pkg::PADDR_W-1:2] == mlcr_pkg::CFG_IDX_TIMEOUT);
    assign prdata  = reg_sel ? {16'h0000, r_timeout_ms} : '0;

    // Write the timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms <= mlcr_pkg::TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_timeout_ms <= pwdata[15:0];
        end
    end

    mlcr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_timeout_ms (r_timeout_ms),
        .i_q_full     (q_full),
        .o_job        (push_job),
        .o_push       (push)
    );

    mlcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    mlcr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_q_pop   (q_pop),
        .o_rsp     (o_rsp)
    );

endmodule

`default_nettype wire
